// File: design/svdc_pkg.sv
package svdc_pkg;

	// operation selector codes
	localparam logic [1:0] FUNC_ENCODE = 2'd0;
	localparam logic [1:0] FUNC_DECODE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	// code byte constants
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [7:0] GROUP_MASK = 8'h7f;
	localparam logic [7:0] INV_MASK   = 8'hff;
	localparam logic [7:0] ONE_MAX    = 8'd127;

	// most code bytes one encode can give
	localparam int MAX_CODES = 3;

	// one queued job: up to three result bytes plus the decoder snapshot
	typedef struct packed {
		logic [MAX_CODES-1:0][7:0] codes;
		logic [1:0]                last_idx;
		logic                      rerr;
		logic [31:0]               total;
		logic                      ended;
		logic [15:0]               bytes_used;
	} entry_t;

	// queue status seen by the front and back parts
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// File: design/size_delta_varint_codec_unit.sv
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-----------------------------------------
// in      | input     | in_valid / in_stall | func, delta, stored_byte
// out     | output    | out_valid/out_stall | code_byte, last, total, ended,
//         |           |                     | bytes_used, range_error
//
// An input transfers each cycle the job queue has room; decode and clear give
// one result, a nonzero encode one to three, at one result per cycle while out_stall is low.
// A three-byte encode holds the back end until its third byte is loaded; decodes sustain one.
// Inputs enter the job queue; the output register loads results from its head.
// arst_n clears the decoder state, the queue and out_valid.
// out_stall holds the output register and, once the queue fills, raises in_stall.
module size_delta_varint_codec_unit import svdc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic signed [31:0] delta,
	input  logic [7:0]  stored_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last,
	output logic [31:0] total,
	output logic        ended,
	output logic [15:0] bytes_used,
	output logic        range_error
);

	logic    push, pop;
	entry_t  push_entry, head;
	q_stat_t q_stat;

	svdc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.delta       (delta),
		.stored_byte (stored_byte),
		.q_stat      (q_stat),
		.push        (push),
		.push_entry  (push_entry)
	);

	svdc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	svdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_byte   (code_byte),
		.last        (last),
		.total       (total),
		.ended       (ended),
		.bytes_used  (bytes_used),
		.range_error (range_error)
	);

`ifndef SYNTHESIS
	// never pop an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// every non-final result of an item is a continuation byte, stored inverted with bit 7 clear
	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !code_byte[7])
		else $error("non-final result is not a continuation byte");

	// an out-of-range encode marks bit 7 only on its final byte
	a_rerr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (code_byte[7] == last))
		else $error("range error result has wrong byte shape");

	// a full queue stalls the input on the next cycle unless it drains
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !pop) |=> in_stall)
		else $error("full queue did not stall input");
`endif

endmodule

// File: design/svdc_front.sv
module svdc_front import svdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] delta,
	input  logic [7:0]  stored_byte,
	input  q_stat_t     q_stat,
	output logic        push,
	output entry_t      push_entry
);

	logic [31:0] sum_q, group_q;
	logic        in_group_q, done_q;
	logic [15:0] count_q;

	logic [31:0] sum_d, group_d;
	logic        in_group_d, done_d;
	logic [15:0] count_d;

	logic        accept;
	logic        fits13, fits20, one_byte, zero_delta;
	logic [7:0]  c;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	// classify the delta by its signed range
	assign fits13     = (&delta[31:13]) || !(|delta[31:13]);
	assign fits20     = (&delta[31:20]) || !(|delta[31:20]);
	assign zero_delta = !(|delta);
	assign one_byte   = !(|delta[31:7]) && !zero_delta && (delta[7:0] <= ONE_MAX);
	assign c          = stored_byte ^ INV_MASK;

	// apply one stored byte or a clear to the decoder state
	always_comb begin
		sum_d      = sum_q;
		group_d    = group_q;
		in_group_d = in_group_q;
		done_d     = done_q;
		count_d    = count_q;
		if (accept && func == FUNC_CLEAR) begin
			sum_d      = '0;
			group_d    = '0;
			in_group_d = 1'b0;
			done_d     = 1'b0;
			count_d    = '0;
		end else if (accept && func == FUNC_DECODE && !done_q) begin
			if (c == 8'd0 && !in_group_q) begin
				done_d = 1'b1;
			end else begin
				if (count_q != 16'hffff)
					count_d = count_q + 16'd1;
				if ((c & CONT_BIT) != 8'd0) begin
					if (!in_group_q) begin
						group_d = {{18{c[6]}}, c[6:0], 7'b0};
					end else begin
						group_d = {group_q[24:7], c[6:0], 7'b0};
					end
					in_group_d = 1'b1;
				end else begin
					sum_d      = sum_q + (group_q | {24'b0, c});
					group_d    = '0;
					in_group_d = 1'b0;
				end
			end
		end
	end

	// build the queue entry
	always_comb begin
		push_entry            = '0;
		push_entry.total      = sum_d;
		push_entry.ended      = done_d;
		push_entry.bytes_used = count_d;
		push                  = 1'b0;
		case (func)
			FUNC_ENCODE: begin
				push            = accept && !zero_delta;
				push_entry.rerr = !fits20;
				if (one_byte) begin
					push_entry.codes[0] = {1'b0, delta[6:0]} ^ INV_MASK;
					push_entry.last_idx = 2'd0;
				end else if (fits13) begin
					push_entry.codes[0] = (CONT_BIT | {1'b0, delta[13:7]}) ^ INV_MASK;
					push_entry.codes[1] = ({1'b0, delta[6:0]} & GROUP_MASK) ^ INV_MASK;
					push_entry.last_idx = 2'd1;
				end else begin
					push_entry.codes[0] = (CONT_BIT | {1'b0, delta[20:14]}) ^ INV_MASK;
					push_entry.codes[1] = (CONT_BIT | {1'b0, delta[13:7]}) ^ INV_MASK;
					push_entry.codes[2] = ({1'b0, delta[6:0]} & GROUP_MASK) ^ INV_MASK;
					push_entry.last_idx = 2'd2;
				end
			end
			FUNC_DECODE, FUNC_CLEAR: begin
				push = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			group_q    <= '0;
			in_group_q <= 1'b0;
			done_q     <= 1'b0;
			count_q    <= '0;
		end else begin
			sum_q      <= sum_d;
			group_q    <= group_d;
			in_group_q <= in_group_d;
			done_q     <= done_d;
			count_q    <= count_d;
		end
	end

endmodule

// File: design/svdc_queue.sv
module svdc_queue import svdc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output entry_t  head,
	output q_stat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == CW'(0));
	assign q_stat.full  = (count_q == CW'(DEPTH));

	// store entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: design/svdc_back.sv
module svdc_back import svdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last,
	output logic [31:0] total,
	output logic        ended,
	output logic [15:0] bytes_used,
	output logic        range_error
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       at_last;

	assign load      = !q_stat.empty && (!valid_q || !out_stall);
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = load && at_last;
	assign out_valid = valid_q;

	// step through the bytes of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load)
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			code_byte   <= head.codes[idx_q];
			last        <= at_last;
			total       <= head.total;
			ended       <= head.ended;
			bytes_used  <= head.bytes_used;
			range_error <= head.rerr;
		end
	end

endmodule
